@@ rtl/rcts_pkg.sv @@
// Package for the RC oscillator trim search block.
// Holds constants, the controller state type and the controller/datapath interface structs.
// No dependencies.
package rcts_pkg;

  localparam int unsigned TRIM_W    = 4;
  localparam int unsigned FREQ_W    = 32;
  localparam int unsigned CNT_IN_W  = 32;
  localparam int unsigned REFC_W    = 16;
  localparam int unsigned TGT_W     = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 20;

  localparam int unsigned REF_HZ_W = 25;
  localparam logic [REF_HZ_W-1:0] REF_HZ = REF_HZ_W'(32000000);
  localparam int unsigned NUM_W = REF_HZ_W + REFC_W;

  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam int unsigned TRIM_MAX = 15;
  localparam logic [TRIM_W-1:0] TRIM_LIMIT = TRIM_W'((TRIM_MAX < 15) ? TRIM_MAX : 15);

  localparam logic [FREQ_W-1:0] ERROR_INIT = 32'h7FFF_FFFF;
  localparam logic [FREQ_W-1:0] FREQ_SAT   = 32'hFFFF_FFFF;

  localparam logic [REFC_W-1:0] REF_COUNT_RST   = 16'd100;
  localparam logic [TGT_W-1:0]  TARGET_FREQ_RST = 20'd32000;

  localparam logic [CFG_IDX_W-1:0] REG_REF_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_FREQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OSC_ENABLED = 2'd2;

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_MEASURE = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_FREQ = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul_ld;
    logic div_step;
    logic freq_ld;
    logic commit;
  } rcts_cmd_t;

  typedef struct packed {
    logic busy;
  } rcts_status_t;

endpackage

@@ rtl/rcts_ctrl.sv @@
// Controller state machine for the RC oscillator trim search.
// Sequences capture, multiply, serial divide and commit. Depends on rcts_pkg.
module rcts_ctrl import rcts_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_mode,
  output logic         in_ready,
  input  logic         out_ready,
  output logic         out_valid,
  input  rcts_status_t st,
  output rcts_cmd_t    cmd
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ((in_mode == MODE_MEASURE) && st.busy) ? S_MUL : S_OUT;
        end
      end
      S_MUL: begin
        cmd.mul_ld = 1'b1;
        step_nxt   = '0;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FREQ;
        end
      end
      S_FREQ: begin
        cmd.freq_ld = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/rcts_dp.sv @@
// Datapath for the RC oscillator trim search: configuration registers, search state,
// multiplier, restoring divider, step decision and output register. Depends on rcts_pkg.
module rcts_dp import rcts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_mode,
  input  logic [TRIM_W-1:0]    in_start_trim,
  input  logic [CNT_IN_W-1:0]  in_measured_count,
  input  rcts_cmd_t            cmd,
  output rcts_status_t         st,
  output logic [TRIM_W-1:0]    out_trim_out,
  output logic                 out_done_res,
  output logic                 out_skipped,
  output logic [FREQ_W-1:0]    out_freq_out
);

  logic [REFC_W-1:0]   ref_count_r;
  logic [TGT_W-1:0]    target_freq_r;
  logic                osc_enabled_r;

  logic [TRIM_W-1:0]   cur_trim_r, cur_trim_nxt;
  logic [TRIM_W-1:0]   prev_trim_r, prev_trim_nxt;
  logic [FREQ_W-1:0]   prev_freq_r, prev_freq_nxt;
  logic [FREQ_W-1:0]   prev_err_r, prev_err_nxt;
  logic                busy_r, busy_nxt;
  logic [FREQ_W-1:0]   final_freq_r, final_freq_nxt;

  logic                mode_r;
  logic [TRIM_W-1:0]   start_r;
  logic [CNT_IN_W-1:0] count_r;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [CNT_IN_W-1:0] rem_r, rem_nxt;
  logic [FREQ_W-1:0]   freq_r, freq_nxt;
  logic [FREQ_W-1:0]   err_r, err_nxt;

  logic [TRIM_W-1:0]   o_trim_r, o_trim_nxt;
  logic                o_done_r, o_done_nxt;
  logic                o_skip_r, o_skip_nxt;
  logic [FREQ_W-1:0]   o_freq_r, o_freq_nxt;

  logic [CNT_IN_W:0]   rem_sh;
  logic                rem_ge;
  logic [FREQ_W-1:0]   tgt_ext;
  logic                sat;
  logic                fin;
  logic [FREQ_W-1:0]   fr;

  assign st.busy      = busy_r;
  assign out_trim_out = o_trim_r;
  assign out_done_res = o_done_r;
  assign out_skipped  = o_skip_r;
  assign out_freq_out = o_freq_r;

  assign tgt_ext = FREQ_W'(target_freq_r);
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, count_r});
  assign sat     = (count_r == '0) || (|num_r[NUM_W-1:FREQ_W]);

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    freq_nxt = freq_r;
    err_nxt  = err_r;
    if (cmd.mul_ld) begin
      num_nxt = NUM_W'(REF_HZ) * NUM_W'(ref_count_r);
      rem_nxt = '0;
    end
    if (cmd.div_step) begin
      num_nxt = {num_r[NUM_W-2:0], rem_ge};
      rem_nxt = rem_ge ? CNT_IN_W'(rem_sh - {1'b0, count_r}) : rem_sh[CNT_IN_W-1:0];
    end
    if (cmd.freq_ld) begin
      freq_nxt = sat ? FREQ_SAT : num_r[FREQ_W-1:0];
      err_nxt  = sat ? (FREQ_SAT - tgt_ext) :
                 ((num_r[FREQ_W-1:0] >= tgt_ext) ? (num_r[FREQ_W-1:0] - tgt_ext)
                                                  : (tgt_ext - num_r[FREQ_W-1:0]));
    end
  end

  always_comb begin
    cur_trim_nxt   = cur_trim_r;
    prev_trim_nxt  = prev_trim_r;
    prev_freq_nxt  = prev_freq_r;
    prev_err_nxt   = prev_err_r;
    busy_nxt       = busy_r;
    final_freq_nxt = final_freq_r;
    o_trim_nxt     = o_trim_r;
    o_done_nxt     = o_done_r;
    o_skip_nxt     = o_skip_r;
    o_freq_nxt     = o_freq_r;
    fin            = 1'b0;
    fr             = freq_r;
    if (cmd.commit) begin
      if (mode_r == MODE_START) begin
        if (!osc_enabled_r) begin
          o_trim_nxt = start_r;
          o_done_nxt = 1'b1;
          o_skip_nxt = 1'b1;
          o_freq_nxt = final_freq_r;
        end else begin
          cur_trim_nxt  = start_r;
          prev_trim_nxt = start_r;
          prev_freq_nxt = '0;
          prev_err_nxt  = ERROR_INIT;
          busy_nxt      = 1'b1;
          o_trim_nxt    = start_r;
          o_done_nxt    = 1'b0;
          o_skip_nxt    = 1'b0;
          o_freq_nxt    = '0;
        end
      end else if (!busy_r) begin
        o_trim_nxt = cur_trim_r;
        o_done_nxt = 1'b1;
        o_skip_nxt = 1'b0;
        o_freq_nxt = final_freq_r;
      end else begin
        if (err_r > prev_err_r) begin
          fr           = prev_freq_r;
          cur_trim_nxt = prev_trim_r;
          fin          = 1'b1;
        end else if (freq_r > tgt_ext) begin
          if (cur_trim_r != '0) begin
            prev_trim_nxt = cur_trim_r;
            cur_trim_nxt  = cur_trim_r - 1'b1;
          end else begin
            fin = 1'b1;
          end
        end else if (freq_r < tgt_ext) begin
          if (cur_trim_r < TRIM_LIMIT) begin
            prev_trim_nxt = cur_trim_r;
            cur_trim_nxt  = cur_trim_r + 1'b1;
          end else begin
            fin = 1'b1;
          end
        end else begin
          fin = 1'b1;
        end
        prev_freq_nxt = fr;
        prev_err_nxt  = err_r;
        o_trim_nxt    = cur_trim_nxt;
        o_skip_nxt    = 1'b0;
        o_done_nxt    = fin;
        if (fin) begin
          busy_nxt       = 1'b0;
          final_freq_nxt = fr;
          o_freq_nxt     = fr;
        end else begin
          o_freq_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_count_r   <= REF_COUNT_RST;
      target_freq_r <= TARGET_FREQ_RST;
      osc_enabled_r <= 1'b1;
      cur_trim_r    <= '0;
      prev_trim_r   <= '0;
      prev_freq_r   <= '0;
      prev_err_r    <= ERROR_INIT;
      busy_r        <= 1'b0;
      final_freq_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_REF_COUNT:   ref_count_r   <= cfg_wdata[REFC_W-1:0];
          REG_TARGET_FREQ: target_freq_r <= cfg_wdata[TGT_W-1:0];
          REG_OSC_ENABLED: osc_enabled_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      cur_trim_r   <= cur_trim_nxt;
      prev_trim_r  <= prev_trim_nxt;
      prev_freq_r  <= prev_freq_nxt;
      prev_err_r   <= prev_err_nxt;
      busy_r       <= busy_nxt;
      final_freq_r <= final_freq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      start_r <= in_start_trim;
      count_r <= in_measured_count;
    end
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    freq_r   <= freq_nxt;
    err_r    <= err_nxt;
    o_trim_r <= o_trim_nxt;
    o_done_r <= o_done_nxt;
    o_skip_r <= o_skip_nxt;
    o_freq_r <= o_freq_nxt;
  end

endmodule

@@ rtl/rc_oscillator_trim_search.sv @@
// Top level of the RC oscillator trim search block.
// Instantiates rcts_ctrl and rcts_dp; depends on rcts_pkg.
//
// A start transfer (mode 0) loads the trim in effect and starts a search; with the oscillator
// disabled it returns that trim as done and skipped. A measurement transfer (mode 1)
// during a search passes through a multiply state, a 41-step restoring divider that forms
// 32e6 * ref_count / measured_count one quotient bit per cycle, and a state that forms the
// frequency and its error, before its result is presented. Measurements outside a search go
// straight to the output state. One item is worked on at a time, so the next transfer is
// accepted only once the controller is back in idle. The next item may be accepted while the
// previous result still waits in the output register. A new result is held back in the output
// state for as long as the waiting result stays unread.
module rc_oscillator_trim_search import rcts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [TRIM_W-1:0]    in_start_trim,
  input  logic [CNT_IN_W-1:0]  in_measured_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TRIM_W-1:0]    out_trim_out,
  output logic                 out_done_res,
  output logic                 out_skipped,
  output logic [FREQ_W-1:0]    out_freq_out
);

  rcts_cmd_t    cmd;
  rcts_status_t st;

  rcts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  rcts_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_mode           (in_mode),
    .in_start_trim     (in_start_trim),
    .in_measured_count (in_measured_count),
    .cmd               (cmd),
    .st                (st),
    .out_trim_out      (out_trim_out),
    .out_done_res      (out_done_res),
    .out_skipped       (out_skipped),
    .out_freq_out      (out_freq_out)
  );

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in progress");

  a_skip_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_skipped) |-> out_done_res)
    else $error("skipped result without done flag");

  a_freq_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> (out_freq_out == '0))
    else $error("nonzero frequency while search is running");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_trim_out) &&
     $stable(out_done_res) && $stable(out_skipped) && $stable(out_freq_out)))
    else $error("result changed while its transfer was pending");

endmodule
